>>> src/ctcg_pkg.sv
// countdown tile colour generator: shared constants and glyph tables
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package ctcg_pkg;

	// tile grid
	localparam int GRID_COLS = 46;
	localparam int GRID_ROWS = 56;
	localparam int TILES     = GRID_COLS * GRID_ROWS;
	localparam int IDX_W     = $clog2(TILES + 1);
	localparam int ELAPSED_W = 24;
	localparam int PROD_W    = ELAPSED_W + IDX_W;
	localparam int POS_W     = 6;

	// text block placement, MM:SS is 46 x 14 tiles
	localparam int GLYPH_W = 46;
	localparam int GLYPH_H = 14;
	localparam int TEXT_C0 = (GRID_COLS - GLYPH_W) / 2;
	localparam int TEXT_R0 = (GRID_ROWS - GLYPH_H) / 2;

	// column layout relative to the text origin
	localparam logic [5:0] X_MIN_TENS = 6'd0;
	localparam logic [5:0] X_MIN_ONES = 6'd11;
	localparam logic [5:0] X_COLON_L  = 6'd22;
	localparam logic [5:0] X_COLON_R  = 6'd23;
	localparam logic [5:0] X_SEC_TENS = 6'd25;
	localparam logic [5:0] X_SEC_ONES = 6'd36;
	localparam logic [5:0] DIGIT_SPAN = 6'd9;

	// duration register
	localparam logic [7:0] DUR_RESET = 8'd25;
	localparam logic [7:0] DUR_MIN   = 8'd1;
	localparam logic [7:0] DUR_MAX   = 8'd180;

	// time arithmetic
	localparam logic [23:0] MS_PER_MIN  = 24'd60000;
	localparam logic [24:0] SEC_RECIP   = 25'd17179870; // ceil(2^34 / 1000)
	localparam int          SEC_SHIFT   = 34;
	localparam logic [14:0] MIN_RECIP   = 15'd17477;    // ceil(2^20 / 60)
	localparam int          MIN_SHIFT   = 20;
	localparam logic [7:0]  DEC_RECIP   = 8'd205;       // ceil(2^11 / 10)
	localparam int          DEC_SHIFT   = 11;
	localparam logic [6:0]  MAX_MIN_SHOWN = 7'd99;

	// colours, RGB565
	localparam logic [15:0] CLR_RED    = 16'h8000;
	localparam logic [15:0] CLR_RED_LT = 16'hFEC8;
	localparam logic [15:0] CLR_GRN_LT = 16'h57E8;
	localparam logic [15:0] CLR_GRN_DK = 16'h0420;

	// register map
	localparam logic REG_DURATION = 1'b0;

	// 5x7 font, one row of five pixels, msb is the leftmost pixel
	function automatic logic [4:0] font_row(input logic [3:0] dig, input logic [2:0] fr);
		logic [34:0] g;
		begin
			case (dig)
				4'd0:    g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
				4'd1:    g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
				4'd2:    g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
				4'd3:    g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
				4'd4:    g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
				4'd5:    g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
				4'd6:    g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
				4'd7:    g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08};
				4'd8:    g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
				4'd9:    g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
				default: g = '0;
			endcase
			case (fr)
				3'd0:    font_row = g[34:30];
				3'd1:    font_row = g[29:25];
				3'd2:    font_row = g[24:20];
				3'd3:    font_row = g[19:15];
				3'd4:    font_row = g[14:10];
				3'd5:    font_row = g[9:5];
				3'd6:    font_row = g[4:0];
				default: font_row = '0;
			endcase
		end
	endfunction

endpackage

>>> src/countdown_tile_colour_generator.sv
// countdown tile colour generator: seven-stage tile pipeline and duration register
// depends on ctcg_pkg
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall) carries one tile per transaction:
//   elapsed_ms, finished, tile_row, tile_col. A transaction completes at a
//   rising edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall) returns colour, is_consumed and
//   is_text for each tile, in request order, one transaction per tile.
//   duration_minutes is written over the APB port at byte address 0 while
//   no tile is in flight; pready is always high, reads return the register.
// Pipeline and throughput
//   Seven register stages: a tile accepted on the request channel passes through
//   stages s1 to s7 in order and is shown on the response channel from s7. One
//   tile per cycle is sustained, since every stage advances in each cycle that
//   the output is not held; the seven stages cover the time split, reciprocal
//   multiplies, digit split and font lookup.
// Reset
//   arst_n clears all stage valid bits and loads duration_minutes with 25.
// Stall
//   While rsp_stall holds a result, earlier stages keep advancing into empty
//   slots; req_stall rises only once all seven stages hold a tile.
module countdown_tile_colour_generator
	import ctcg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// apb configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [ELAPSED_W-1:0] elapsed_ms,
	input  logic                 finished,
	input  logic [POS_W-1:0]     tile_row,
	input  logic [POS_W-1:0]     tile_col,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [15:0]          colour,
	output logic                 is_consumed,
	output logic                 is_text
);

	// configuration register
	logic [7:0] duration_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= DUR_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DURATION)) begin
			duration_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_DURATION) ? {24'd0, duration_q} : 32'd0;

	// stage valids and advance chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	assign adv_s7 = !v_s7 || !rsp_stall;
	assign adv_s6 = !v_s6 || adv_s7;
	assign adv_s5 = !v_s5 || adv_s6;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;

	assign req_stall = !adv_s1;
	assign rsp_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= req_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
		end
	end

	// stage 1: total time, tile index, text-relative position
	logic [7:0]       m_cl;
	logic [23:0]      total_c;
	logic [IDX_W-1:0] idx1_c;
	logic             on_grid_c;
	logic [5:0]       x_c;
	logic [5:0]       y_c;
	logic             in_glyph_c;

	always_comb begin
		if (duration_q < DUR_MIN) begin
			m_cl = DUR_MIN;
		end else if (duration_q > DUR_MAX) begin
			m_cl = DUR_MAX;
		end else begin
			m_cl = duration_q;
		end
		total_c    = 24'(m_cl) * MS_PER_MIN;
		idx1_c     = IDX_W'(tile_row) * IDX_W'(GRID_COLS) + IDX_W'(tile_col) + IDX_W'(1);
		on_grid_c  = (tile_row < POS_W'(GRID_ROWS)) && (tile_col < POS_W'(GRID_COLS));
		x_c        = tile_col - POS_W'(TEXT_C0);
		y_c        = tile_row - POS_W'(TEXT_R0);
		in_glyph_c = on_grid_c && (tile_col >= POS_W'(TEXT_C0)) && (tile_row >= POS_W'(TEXT_R0))
			&& (x_c < 6'(GLYPH_W)) && (y_c < 6'(GLYPH_H));
	end

	logic [ELAPSED_W-1:0] elapsed_s1;
	logic                 fin_s1;
	logic [23:0]          total_s1;
	logic [IDX_W-1:0]     idx1_s1;
	logic                 on_grid_s1;
	logic                 in_glyph_s1;
	logic [5:0]           x_s1;
	logic [3:0]           y_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			elapsed_s1  <= elapsed_ms;
			fin_s1      <= finished;
			total_s1    <= total_c;
			idx1_s1     <= idx1_c;
			on_grid_s1  <= on_grid_c;
			in_glyph_s1 <= in_glyph_c;
			x_s1        <= x_c;
			y_s1        <= y_c[3:0];
		end
	end

	// stage 2: remaining time and cross-multiplied consumed compare operands
	logic [23:0]       rem_c;
	logic [PROD_W-1:0] prod_a_c;
	logic [PROD_W-1:0] prod_b_c;

	always_comb begin
		if (fin_s1 || (elapsed_s1 >= total_s1)) begin
			rem_c = '0;
		end else begin
			rem_c = total_s1 - elapsed_s1;
		end
		prod_a_c = PROD_W'(idx1_s1) * PROD_W'(total_s1);
		prod_b_c = PROD_W'(elapsed_s1) * PROD_W'(TILES);
	end

	logic [23:0]       rem_s2;
	logic [PROD_W-1:0] prod_a_s2;
	logic [PROD_W-1:0] prod_b_s2;
	logic              fin_s2;
	logic              on_grid_s2;
	logic              in_glyph_s2;
	logic [5:0]        x_s2;
	logic [3:0]        y_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rem_s2      <= rem_c;
			prod_a_s2   <= prod_a_c;
			prod_b_s2   <= prod_b_c;
			fin_s2      <= fin_s1;
			on_grid_s2  <= on_grid_s1;
			in_glyph_s2 <= in_glyph_s1;
			x_s2        <= x_s1;
			y_s2        <= y_s1;
		end
	end

	// stage 3: whole seconds remaining, consumed decision
	// idx < floor(e*T/total) holds exactly when (idx+1)*total <= e*T
	logic [48:0] sec_prod_c;
	logic        cons_c;

	always_comb begin
		sec_prod_c = 49'(rem_s2) * 49'(SEC_RECIP);
		cons_c     = on_grid_s2 && (fin_s2 || (prod_a_s2 <= prod_b_s2));
	end

	logic [13:0] sect_s3;
	logic        cons_s3;
	logic        in_glyph_s3;
	logic [5:0]  x_s3;
	logic [3:0]  y_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			sect_s3     <= sec_prod_c[SEC_SHIFT+13:SEC_SHIFT];
			cons_s3     <= cons_c;
			in_glyph_s3 <= in_glyph_s2;
			x_s3        <= x_s2;
			y_s3        <= y_s2;
		end
	end

	// stage 4: whole minutes remaining
	logic [28:0] min_prod_c;

	assign min_prod_c = 29'(sect_s3) * 29'(MIN_RECIP);

	logic [7:0]  min_raw_s4;
	logic [13:0] sect_s4;
	logic        cons_s4;
	logic        in_glyph_s4;
	logic [5:0]  x_s4;
	logic [3:0]  y_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			min_raw_s4  <= min_prod_c[MIN_SHIFT+7:MIN_SHIFT];
			sect_s4     <= sect_s3;
			cons_s4     <= cons_s3;
			in_glyph_s4 <= in_glyph_s3;
			x_s4        <= x_s3;
			y_s4        <= y_s3;
		end
	end

	// stage 5: seconds field and minute saturation
	logic [13:0] sec_diff_c;
	logic [6:0]  mins_c;

	always_comb begin
		sec_diff_c = sect_s4 - 14'(min_raw_s4) * 14'd60;
		mins_c     = (min_raw_s4 > 8'(MAX_MIN_SHOWN)) ? MAX_MIN_SHOWN : min_raw_s4[6:0];
	end

	logic [6:0] mins_s5;
	logic [5:0] secs_s5;
	logic       cons_s5;
	logic       in_glyph_s5;
	logic [5:0] x_s5;
	logic [3:0] y_s5;

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			mins_s5     <= mins_c;
			secs_s5     <= sec_diff_c[5:0];
			cons_s5     <= cons_s4;
			in_glyph_s5 <= in_glyph_s4;
			x_s5        <= x_s4;
			y_s5        <= y_s4;
		end
	end

	// stage 6: pick the glyph under this column and split its value into a digit
	logic [6:0]  val_c;
	logic [14:0] tens_prod_c;
	logic [3:0]  tens_c;
	logic [3:0]  ones_c;
	logic [3:0]  dig_c;
	logic [3:0]  lx_c;
	logic        is_digit_c;
	logic        is_colon_c;

	always_comb begin
		val_c       = (x_s5 <= X_MIN_ONES + DIGIT_SPAN) ? mins_s5 : 7'(secs_s5);
		tens_prod_c = 15'(val_c) * 15'(DEC_RECIP);
		tens_c      = tens_prod_c[DEC_SHIFT+3:DEC_SHIFT];
		ones_c      = 4'(val_c - 7'(tens_c) * 7'd10);
		dig_c       = '0;
		lx_c        = '0;
		is_digit_c  = 1'b0;
		is_colon_c  = 1'b0;
		if (x_s5 <= X_MIN_TENS + DIGIT_SPAN) begin
			dig_c      = tens_c;
			lx_c       = 4'(x_s5 - X_MIN_TENS);
			is_digit_c = in_glyph_s5;
		end else if ((x_s5 >= X_MIN_ONES) && (x_s5 <= X_MIN_ONES + DIGIT_SPAN)) begin
			dig_c      = ones_c;
			lx_c       = 4'(x_s5 - X_MIN_ONES);
			is_digit_c = in_glyph_s5;
		end else if ((x_s5 == X_COLON_L) || (x_s5 == X_COLON_R)) begin
			is_colon_c = in_glyph_s5;
		end else if ((x_s5 >= X_SEC_TENS) && (x_s5 <= X_SEC_TENS + DIGIT_SPAN)) begin
			dig_c      = tens_c;
			lx_c       = 4'(x_s5 - X_SEC_TENS);
			is_digit_c = in_glyph_s5;
		end else if (x_s5 >= X_SEC_ONES) begin
			dig_c      = ones_c;
			lx_c       = 4'(x_s5 - X_SEC_ONES);
			is_digit_c = in_glyph_s5;
		end
	end

	logic [3:0] dig_s6;
	logic [3:0] lx_s6;
	logic       is_digit_s6;
	logic       is_colon_s6;
	logic       cons_s6;
	logic [3:0] y_s6;

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			dig_s6      <= dig_c;
			lx_s6       <= lx_c;
			is_digit_s6 <= is_digit_c;
			is_colon_s6 <= is_colon_c;
			cons_s6     <= cons_s5;
			y_s6        <= y_s5;
		end
	end

	// stage 7: font lookup, colon dots and colour
	logic [4:0]  frow_c;
	logic [2:0]  fc_c;
	logic        text_c;
	logic [15:0] colour_c;

	always_comb begin
		frow_c = font_row(dig_s6, y_s6[3:1]);
		fc_c   = lx_s6[3:1];
		if (is_digit_s6) begin
			text_c = (fc_c <= 3'd4) && frow_c[3'd4 - fc_c];
		end else if (is_colon_s6) begin
			text_c = (y_s6 == 4'd4) || (y_s6 == 4'd5) || (y_s6 == 4'd9) || (y_s6 == 4'd10);
		end else begin
			text_c = 1'b0;
		end
		if (cons_s6) begin
			colour_c = text_c ? CLR_RED_LT : CLR_RED;
		end else begin
			colour_c = text_c ? CLR_GRN_LT : CLR_GRN_DK;
		end
	end

	logic [15:0] colour_s7;
	logic        cons_s7;
	logic        text_s7;

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			colour_s7 <= colour_c;
			cons_s7   <= cons_s6;
			text_s7   <= text_c;
		end
	end

	assign colour      = colour_s7;
	assign is_consumed = cons_s7;
	assign is_text     = text_s7;

`ifndef NO_ASSERTIONS
	// request side only blocks once every stage holds a tile
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7))
		else $error("request stalled with an empty pipeline slot");

	// reciprocal split gives a legal minutes and seconds pair
	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ((mins_s5 <= MAX_MIN_SHOWN) && (secs_s5 < 6'd60)))
		else $error("minutes or seconds out of range");

	// decimal split yields a font digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && is_digit_s6) |-> (dig_s6 <= 4'd9))
		else $error("digit out of range");

	// once the response side is released, the tile in stage 6 moves into stage 7
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && v_s7 && !rsp_stall) |=> v_s7)
		else $error("tile lost between last two stages");

	// colour agrees with the consumed and text flags
	a_colour_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((is_consumed && is_text && (colour == CLR_RED_LT))
			|| (is_consumed && !is_text && (colour == CLR_RED))
			|| (!is_consumed && is_text && (colour == CLR_GRN_LT))
			|| (!is_consumed && !is_text && (colour == CLR_GRN_DK))))
		else $error("colour does not match tile flags");
`endif

endmodule

>>> tb/countdown_tile_colour_generator_tb.sv
// testbench for countdown_tile_colour_generator: random and directed tiles on the request
// channel, a local per-tile colour predictor and an in-order scoreboard on the response channel
// depends on ctcg_pkg and the countdown_tile_colour_generator rtl
`timescale 1ns / 1ps

module countdown_tile_colour_generator_tb;
	import ctcg_pkg::*;

	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES   = 16;
	localparam logic [2:0]  DURATION_ADDR  = {REG_DURATION, 2'b00};

	// 5x7 digit font, seven rows per digit, msb is the leftmost pixel
	localparam logic [4:0] DIGIT_FONT [70] = '{
		5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,
		5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E,
		5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F,
		5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E,
		5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02,
		5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E,
		5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E,
		5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08,
		5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E,
		5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C
	};

	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed;
		logic                 fin;
		logic [POS_W-1:0]     row;
		logic [POS_W-1:0]     col;
	} tile_req_t;

	typedef struct packed {
		logic [15:0] colour;
		logic        cons;
		logic        text;
	} tile_shade_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	logic                 req_valid  = 1'b0;
	logic                 req_stall;
	logic [ELAPSED_W-1:0] elapsed_ms = '0;
	logic                 finished   = 1'b0;
	logic [POS_W-1:0]     tile_row   = '0;
	logic [POS_W-1:0]     tile_col   = '0;

	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [15:0] colour;
	logic        is_consumed;
	logic        is_text;

	tile_req_t   tile_requests [$];
	tile_shade_t shade_expected [$];

	logic [7:0] duration_cfg  = DUR_RESET;
	bit         quiet         = 1'b0;
	bit         req_took      = 1'b0;
	int         req_gap       = 0;
	int         rsp_gap       = 0;
	int         sent_count    = 0;
	int         checked_count = 0;
	int         idle_cycles   = 0;
	int         errors        = 0;

	countdown_tile_colour_generator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.elapsed_ms  (elapsed_ms),
		.finished    (finished),
		.tile_row    (tile_row),
		.tile_col    (tile_col),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.colour      (colour),
		.is_consumed (is_consumed),
		.is_text     (is_text)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// countdown length in ms after clamping the register
	function automatic int unsigned total_ms(input logic [7:0] dur);
		int unsigned m;
		begin
			m = 32'(dur);
			if (m < DUR_MIN) m = DUR_MIN;
			if (m > DUR_MAX) m = DUR_MAX;
			return m * MS_PER_MIN;
		end
	endfunction

	// font pixel of digit d at local column lx, glyph row ry, scaled 2x
	function automatic logic glyph_lit(input int unsigned d, input int unsigned lx,
		input int unsigned ry);
		int unsigned fr;
		int unsigned fc;
		logic [4:0]  bits;
		begin
			fr = ry >> 1;
			fc = lx >> 1;
			if (d > 9 || fr > 6 || fc > 4) return 1'b0;
			bits = DIGIT_FONT[d * 7 + fr];
			return bits[4 - fc];
		end
	endfunction

	// expected colour, consumed and text flags of one tile
	function automatic tile_shade_t shade_of_tile(input logic [7:0] dur, input tile_req_t t);
		int unsigned     total;
		int unsigned     rem;
		int unsigned     mins;
		int unsigned     secs;
		int unsigned     x;
		int unsigned     y;
		longint unsigned consumed;
		longint unsigned idx;
		tile_shade_t     s;
		begin
			total = total_ms(dur);
			rem   = (t.elapsed < total) ? total - t.elapsed : 0;
			if (t.fin) rem = 0;
			mins = rem / MS_PER_MIN;
			secs = (rem % MS_PER_MIN) / 1000;
			if (mins > MAX_MIN_SHOWN) mins = MAX_MIN_SHOWN;

			consumed = 64'(t.elapsed);
			consumed = consumed * TILES / total;
			if (consumed > TILES) consumed = TILES;
			if (t.fin) consumed = TILES;

			s.cons = 1'b0;
			s.text = 1'b0;
			if (t.row < GRID_ROWS && t.col < GRID_COLS) begin
				idx    = 64'(t.row) * GRID_COLS + 64'(t.col);
				s.cons = idx < consumed;
				if (t.col >= TEXT_C0 && t.row >= TEXT_R0) begin
					x = 32'(t.col) - TEXT_C0;
					y = 32'(t.row) - TEXT_R0;
					if (x < GLYPH_W && y < GLYPH_H) begin
						if (x <= 9)
							s.text = glyph_lit(mins / 10, x, y);
						else if (x >= 11 && x <= 20)
							s.text = glyph_lit(mins % 10, x - 11, y);
						else if (x == 22 || x == 23)
							s.text = (y == 4 || y == 5 || y == 9 || y == 10);
						else if (x >= 25 && x <= 34)
							s.text = glyph_lit(secs / 10, x - 25, y);
						else if (x >= 36)
							s.text = glyph_lit(secs % 10, x - 36, y);
					end
				end
			end

			if (s.cons) s.colour = s.text ? CLR_RED_LT : CLR_RED;
			else        s.colour = s.text ? CLR_GRN_LT : CLR_GRN_DK;
			return s;
		end
	endfunction

	task automatic push_tile(input int unsigned el, input bit fin, input int unsigned row,
		input int unsigned col);
		tile_req_t t;
		begin
			t.elapsed = ELAPSED_W'(el);
			t.fin     = fin;
			t.row     = POS_W'(row);
			t.col     = POS_W'(col);
			tile_requests.push_back(t);
		end
	endtask

	// random tiles, biased to the text band, second boundaries and the consumed boundary
	task automatic queue_random(input int n);
		int unsigned     total;
		int unsigned     el;
		int unsigned     row;
		int unsigned     col;
		int unsigned     k;
		int unsigned     kind;
		longint unsigned tgt;
		longint unsigned idx;
		bit              fin;
		begin
			total = total_ms(duration_cfg);
			repeat (n) begin
				kind = $urandom_range(0, 99);
				fin  = ($urandom_range(0, 7) == 0);
				if ($urandom_range(0, 1) == 0) begin
					row = TEXT_R0 + $urandom_range(0, GLYPH_H - 1);
					col = TEXT_C0 + $urandom_range(0, GLYPH_W - 1);
				end else if ($urandom_range(0, 5) != 0) begin
					row = $urandom_range(0, GRID_ROWS - 1);
					col = $urandom_range(0, GRID_COLS - 1);
				end else begin
					row = $urandom_range(0, 63);
					col = $urandom_range(0, 63);
				end
				if (kind < 40) begin
					el = $urandom_range(0, total);
				end else if (kind < 55) begin
					el = $urandom() & 32'hFF_FFFF;
				end else if (kind < 70) begin
					el = total - 3000 + $urandom_range(0, 6000);
				end else if (kind < 85) begin
					// second boundaries
					k  = $urandom_range(0, total / 1000);
					el = k * 1000 + $urandom_range(0, 2);
					if (el > 0) el = el - 1;
				end else begin
					// first elapsed value at which tile tgt-1 turns consumed
					tgt = $urandom_range(1, TILES);
					el  = 32'((tgt * total + TILES - 1) / TILES - $urandom_range(0, 1));
					idx = tgt - $urandom_range(0, 1);
					if (idx >= TILES) idx = TILES - 1;
					row = 32'(idx / GRID_COLS);
					col = 32'(idx % GRID_COLS);
				end
				push_tile(el, fin, row, col);
			end
		end
	endtask

	// wait until every queued tile has been sent and answered
	task automatic wait_drained();
		begin
			do @(negedge clk);
			while (!(tile_requests.size() == 0 && sent_count == checked_count));
		end
	endtask

	// apb write of the duration register, setup then access
	task automatic write_duration(input logic [7:0] value);
		begin
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= DURATION_ADDR;
			pwdata  <= {24'($urandom_range(0, 32'hFF_FFFF)), value};
			@(negedge clk);
			penable <= 1'b1;
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			duration_cfg = value;
		end
	endtask

	// request driver, holds the payload while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_took) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (tile_requests.size() > 0) begin
				tile_req_t t;
				t = tile_requests.pop_front();
				elapsed_ms <= t.elapsed;
				finished   <= t.fin;
				tile_row   <= t.row;
				tile_col   <= t.col;
				req_valid  <= 1'b1;
				sent_count++;
				if (!quiet && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 16);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response back-pressure in bursts
	always @(negedge clk) begin
		if (rsp_gap > 0) begin
			rsp_gap--;
			rsp_stall <= 1'b1;
		end else if (arst_n && !quiet && $urandom_range(0, 11) == 0) begin
			rsp_gap = $urandom_range(0, 15);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// monitor: predict on each request transaction, check each response transaction
	always @(posedge clk) begin
		tile_req_t   t;
		tile_shade_t want;
		bit          progress;
		if (arst_n) begin
			progress = 1'b0;
			if (req_valid && !req_stall) begin
				t.elapsed = elapsed_ms;
				t.fin     = finished;
				t.row     = tile_row;
				t.col     = tile_col;
				shade_expected.push_back(shade_of_tile(duration_cfg, t));
				req_took = 1'b1;
				progress = 1'b1;
			end else begin
				req_took = 1'b0;
			end
			if (rsp_valid && !rsp_stall) begin
				progress = 1'b1;
				if (shade_expected.size() == 0) begin
					$display("%0t: response with nothing expected, colour %h", $time, colour);
					errors++;
				end else begin
					want = shade_expected.pop_front();
					checked_count++;
					if (colour !== want.colour) begin
						$display("%0t: colour mismatch, expected %h, actual %h",
							$time, want.colour, colour);
						errors++;
					end
					if (is_consumed !== want.cons) begin
						$display("%0t: is_consumed mismatch, expected %b, actual %b",
							$time, want.cons, is_consumed);
						errors++;
					end
					if (is_text !== want.text) begin
						$display("%0t: is_text mismatch, expected %b, actual %b",
							$time, want.text, is_text);
						errors++;
					end
				end
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// stimulus sequence
	initial begin
		int unsigned total;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed tiles at the reset duration
		total = total_ms(duration_cfg);
		push_tile(0, 1'b0, TEXT_R0, TEXT_C0 + 2);
		push_tile(0, 1'b0, TEXT_R0 + 1, TEXT_C0);
		push_tile(0, 1'b0, TEXT_R0 + 4, TEXT_C0 + 22);
		push_tile(0, 1'b0, TEXT_R0 + 5, TEXT_C0 + 23);
		push_tile(0, 1'b0, TEXT_R0 + 6, TEXT_C0 + 22);
		push_tile(0, 1'b0, TEXT_R0 + 10, TEXT_C0 + 23);
		push_tile(1, 1'b0, TEXT_R0 + 13, TEXT_C0 + 45);
		push_tile(999, 1'b0, TEXT_R0 + 2, TEXT_C0 + 36);
		push_tile(1000, 1'b0, TEXT_R0 + 2, TEXT_C0 + 36);
		push_tile(1001, 1'b0, TEXT_R0 + 12, TEXT_C0 + 27);
		push_tile(total / 2, 1'b0, 27, 45);
		push_tile(total / 2, 1'b0, 28, 0);
		push_tile(total - 1, 1'b0, 55, 44);
		push_tile(total - 1, 1'b0, 55, 45);
		push_tile(total, 1'b0, 55, 45);
		push_tile(24'hFF_FFFF, 1'b0, 55, 45);
		push_tile(24'hFF_FFFF, 1'b0, TEXT_R0 + 3, TEXT_C0 + 12);
		push_tile(0, 1'b1, 0, 0);
		push_tile(0, 1'b1, TEXT_R0, TEXT_C0 + 3);
		push_tile(24'hFF_FFFF, 1'b1, 63, 63);
		push_tile(0, 1'b0, GRID_ROWS, 0);
		push_tile(0, 1'b0, 0, GRID_COLS);
		push_tile(0, 1'b0, 0, 0);
		queue_random(80);
		wait_drained();

		// clamp edges and a spread of durations
		write_duration(8'd1);
		queue_random(100);
		wait_drained();
		write_duration(8'd0);
		queue_random(100);
		wait_drained();
		write_duration(DUR_MAX);
		push_tile(0, 1'b0, TEXT_R0 + 6, TEXT_C0 + 1);
		queue_random(100);
		wait_drained();
		write_duration(8'd255);
		queue_random(50);
		// sender holds off until every result is back
		wait_drained();
		queue_random(50);
		wait_drained();
		write_duration(8'd181);
		queue_random(100);
		wait_drained();
		write_duration(8'd100);
		queue_random(100);
		wait_drained();
		write_duration(8'($urandom_range(2, 179)));
		queue_random(100);
		wait_drained();

		// closing stretch without idling on either side
		quiet = 1'b1;
		write_duration(8'($urandom_range(0, 255)));
		queue_random(100);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (shade_expected.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, shade_expected.size());
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
